// File: sv/mmf_pkg.sv
// Shared types, sizes and register codes of the 3x3 min/max filter.
`default_nettype none

package mmf_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    // Derived counter and size widths
    localparam int COL_W = $clog2(MAX_WIDTH);       // column index into the line RAM
    localparam int WID_W = $clog2(MAX_WIDTH + 1);   // holds the used width itself
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);  // holds the used height itself
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);  // input row runs one past the flush row

    // Channel and pixel sizes
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int LINE_W = 2 * PIX_W;              // {two rows above, row above}

    // Configuration port
    localparam int FW_W      = 12;                  // frame_width register
    localparam int FH_W      = 13;                  // frame_height register
    localparam int CFG_W     = 13;                  // widest register
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd2;

    localparam logic [FW_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd480;

    // Filter modes
    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    // Input item kinds
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_FULL    = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_EMPTY   = 8'h00;

    // Output buffer
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 3);

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    // 3x3 window: [row][col], row 0 is two rows up, col 2 is the newest column
    typedef pixel_t [2:0][2:0] win_t;

    // Per-word control traveling down the pipeline
    typedef struct packed {
        logic valid;
        logic emit;
        logic top_edge;
        logic bottom_edge;
        logic left_edge;
        logic right_edge;
        logic last;
    } ctl_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } result_t;

    // Register value to used width: 0 reads as 1, large values saturate
    function automatic logic [WID_W-1:0] clamp_width(input logic [FW_W-1:0] v);
        if (v == '0)
            return WID_W'(1);
        else if (32'(v) > MAX_WIDTH)
            return WID_W'(MAX_WIDTH);
        else
            return WID_W'(v);
    endfunction

    function automatic logic [HGT_W-1:0] clamp_height(input logic [FH_W-1:0] v);
        if (v == '0)
            return HGT_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            return HGT_W'(MAX_HEIGHT);
        else
            return HGT_W'(v);
    endfunction

endpackage

`default_nettype wire

// File: sv/mmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/mmf_ctrl.sv
// Configuration registers and raster position tracking of the min/max filter.
`default_nettype none

module mmf_ctrl import mmf_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 accept,
    input  wire logic                 command,
    input  wire pixel_t               pix_in,
    output      logic                 filter_mode,
    output      ctl_t                 s0_ctl,
    output      pixel_t               s0_pix,
    output      logic [COL_W-1:0]     s0_addr
);

    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic             mode_reg;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic flushing;
    logic emit_prev_row_end;
    logic emit_mid;
    logic out_col_end;
    logic out_row_end;
    logic in_col_end;

    // Position decode
    always_comb
    begin
        flushing          = in_row_reg >= ROW_W'(height_reg);
        emit_prev_row_end = (in_col_reg == '0) && (in_row_reg >= ROW_W'(2));
        emit_mid          = (in_col_reg != '0) && (in_row_reg != '0);
        out_col_end       = (WID_W'(out_col_reg) + WID_W'(1)) >= width_reg;
        out_row_end       = (out_row_reg + ROW_W'(1)) >= ROW_W'(height_reg);
        in_col_end        = (WID_W'(in_col_reg) + WID_W'(1)) >= width_reg;
    end

    // Word entering the pipeline; a drain inside the frame does nothing
    always_comb
    begin
        s0_ctl.valid       = accept && !((command == CMD_DRAIN) && !flushing);
        s0_ctl.emit        = emit_prev_row_end || emit_mid;
        s0_ctl.top_edge    = (out_row_reg == '0);
        s0_ctl.bottom_edge = out_row_end;
        s0_ctl.left_edge   = (out_col_reg == '0);
        s0_ctl.right_edge  = out_col_end || emit_prev_row_end;
        s0_ctl.last        = out_row_end && out_col_end;
        s0_pix             = flushing ? pixel_t'('0) : pix_in;
        s0_addr            = in_col_reg;
    end

    // Position update
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (s0_ctl.valid)
        begin
            if (s0_ctl.emit && s0_ctl.last)
            begin
                // frame done: start over
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (s0_ctl.emit)
                begin
                    if (out_col_end)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
                if (in_col_end)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Registers; a size write restarts the stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= clamp_width(RESET_WIDTH);
            height_reg  <= clamp_height(RESET_HEIGHT);
            mode_reg    <= MODE_MIN;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_reg   <= clamp_width(cfg_data[FW_W-1:0]);
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg  <= clamp_height(cfg_data[FH_W-1:0]);
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                REG_FILTER_MODE:
                begin
                    mode_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign filter_mode = mode_reg;

endmodule

`default_nettype wire

// File: sv/mmf_window.sv
// Line RAM read-modify-write with forwarding and the 3x3 window registers.
`default_nettype none

module mmf_window import mmf_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctl_t             s0_ctl,
    input  wire pixel_t           s0_pix,
    input  wire logic [COL_W-1:0] s0_addr,
    output      win_t             window,
    output      ctl_t             s2_ctl,
    output      logic             s1_emit
);

    ctl_t             s1_ctl_reg;
    ctl_t             s2_ctl_reg;
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic             fwd_hit_reg, fwd_hit_next;
    logic [LINE_W-1:0] fwd_data_reg;
    win_t             window_reg, window_next;

    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line_word;
    logic [LINE_W-1:0] wr_word;
    pixel_t            above;
    pixel_t            two_above;

    // Each entry holds one column of the two previous rows
    mmf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_ctl_reg.valid),
        .waddr (s1_addr_reg),
        .wdata (wr_word),
        .re    (s0_ctl.valid),
        .raddr (s0_addr),
        .rdata (ram_rdata)
    );

    // Forward the word written on the same edge as this read
    always_comb
    begin
        line_word    = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        two_above    = line_word[LINE_W-1:PIX_W];
        above        = line_word[PIX_W-1:0];
        wr_word      = {above, s1_pix_reg};
        fwd_hit_next = s0_ctl.valid && s1_ctl_reg.valid && (s0_addr == s1_addr_reg);
    end

    // Window shifts left, new column enters at the right
    always_comb
    begin
        window_next = window_reg;
        for (int r = 0; r < 3; r++)
        begin
            window_next[r][0] = window_reg[r][1];
            window_next[r][1] = window_reg[r][2];
        end
        window_next[0][2] = two_above;
        window_next[1][2] = above;
        window_next[2][2] = s1_pix_reg;
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg  <= '0;
            s2_ctl_reg  <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_ctl_reg  <= s0_ctl;
            s2_ctl_reg  <= s1_ctl_reg;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s0_ctl.valid)
        begin
            s1_pix_reg  <= s0_pix;
            s1_addr_reg <= s0_addr;
        end
        if (s1_ctl_reg.valid)
        begin
            window_reg   <= window_next;
            fwd_data_reg <= wr_word;
        end
    end

    assign window  = window_reg;
    assign s2_ctl  = s2_ctl_reg;
    assign s1_emit = s1_ctl_reg.valid && s1_ctl_reg.emit;

endmodule

`default_nettype wire

// File: sv/mmf_reduce.sv
// Per-channel min or max over the 3x3 window, border taps masked out.
`default_nettype none

module mmf_reduce import mmf_pkg::*; (
    input  wire win_t    window,
    input  wire ctl_t    ctl,
    input  wire logic    filter_mode,
    output      result_t result
);

    logic [CHAN_W-1:0]                    neutral;
    logic [2:0][2:0][2:0][CHAN_W-1:0]     taps;     // [row][col][channel]
    logic [2:0][2:0][CHAN_W-1:0]          row_best; // [row][channel]
    logic [2:0][CHAN_W-1:0]               best;     // [channel], 0 is red

    function automatic logic [CHAN_W-1:0] pick(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic              mode
    );
        if (mode == MODE_MAX)
            return (a > b) ? a : b;
        else
            return (a < b) ? a : b;
    endfunction

    // Masked taps take the value that never wins
    always_comb
    begin
        neutral = (filter_mode == MODE_MAX) ? CHAN_EMPTY : CHAN_FULL;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && ctl.top_edge) || (r == 2 && ctl.bottom_edge) ||
                    (c == 0 && ctl.left_edge) || (c == 2 && ctl.right_edge))
                    taps[r][c] = {3{neutral}};
                else
                    taps[r][c] = window[r][c];
            end
        end
    end

    // Two-level tree per row, then two levels across rows
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                row_best[r][ch] = pick(pick(taps[r][0][ch], taps[r][1][ch], filter_mode),
                                       taps[r][2][ch], filter_mode);
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            best[ch] = pick(pick(row_best[0][ch], row_best[1][ch], filter_mode),
                            row_best[2][ch], filter_mode);
        end
    end

    always_comb
    begin
        result.red   = best[0];
        result.green = best[1];
        result.blue  = best[2];
        result.last  = ctl.last;
    end

endmodule

`default_nettype wire

// File: sv/mmf_fifo.sv
// Small result FIFO that decouples the filter pipeline from output stalls.
`default_nettype none

module mmf_fifo import mmf_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire result_t               push_data,
    input  wire logic                  pop,
    output      result_t               head,
    output      logic                  not_empty,
    output      logic [FIFO_CNT_W-1:0] count
);

    result_t               slots [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_data;
    end

    assign head      = slots[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

`default_nettype wire

// File: sv/rgb_3x3_min_max_filter_unit.sv
// Top level of the RGB 3x3 min/max (erosion/dilation) filter.
`default_nettype none

// Takes one RGB word per clock in raster order and returns, per channel, the
// minimum (filter_mode 0) or maximum (filter_mode 1) over each pixel's 3x3
// neighborhood; taps outside the frame are left out and alpha_out is always
// 255. Results lag the input by one row plus one pixel, so after the last
// pixel of a frame send frame_width + 1 drain words (command 1) to flush it;
// frame_last marks the final result, after which the next pixel starts a new
// frame. Drain words inside a frame are dropped, and pixels sent while a frame
// is flushing count as drains. Throughput is one word per clock: each word
// does one read and one write of a single column entry in the line RAM
// (two previous rows side by side), with same-address forwarding between
// back-to-back words. result_valid rises once the word completing a result
// has passed the s1 and s2 stages and been pushed into the result FIFO.
// pixel_stall rises only when four results are in flight or buffered, i.e.
// when the output side holds off. No clearing pass after reset.
// Write the size and mode registers only while the block is idle; a size
// write restarts the frame.
module rgb_3x3_min_max_filter_unit import mmf_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // pixel channel
    input  wire logic                 pixel_valid,
    output      logic                 pixel_stall,
    input  wire logic                 command,
    input  wire logic [CHAN_W-1:0]    red_in,
    input  wire logic [CHAN_W-1:0]    green_in,
    input  wire logic [CHAN_W-1:0]    blue_in,
    // result channel
    output      logic                 result_valid,
    input  wire logic                 result_stall,
    output      logic [CHAN_W-1:0]    red_out,
    output      logic [CHAN_W-1:0]    green_out,
    output      logic [CHAN_W-1:0]    blue_out,
    output      logic [CHAN_W-1:0]    alpha_out,
    output      logic                 frame_last
);

    logic                  accept;
    pixel_t                pix_in;
    logic                  filter_mode;
    ctl_t                  s0_ctl;
    pixel_t                s0_pix;
    logic [COL_W-1:0]      s0_addr;
    win_t                  window;
    ctl_t                  s2_ctl;
    logic                  s1_emit;
    logic                  s2_emit;
    result_t               result;
    result_t               head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [PEND_W-1:0]     pending;

    // Input handshake; stall once every FIFO slot is spoken for
    always_comb
    begin
        s2_emit     = s2_ctl.valid && s2_ctl.emit;
        pending     = PEND_W'(fifo_count) + PEND_W'(s1_emit) + PEND_W'(s2_emit);
        pixel_stall = pending >= PEND_W'(FIFO_DEPTH);
        accept      = pixel_valid && !pixel_stall;
        pix_in      = '{blue: blue_in, green: green_in, red: red_in};
    end

    mmf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .command     (command),
        .pix_in      (pix_in),
        .filter_mode (filter_mode),
        .s0_ctl      (s0_ctl),
        .s0_pix      (s0_pix),
        .s0_addr     (s0_addr)
    );

    mmf_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .s0_ctl  (s0_ctl),
        .s0_pix  (s0_pix),
        .s0_addr (s0_addr),
        .window  (window),
        .s2_ctl  (s2_ctl),
        .s1_emit (s1_emit)
    );

    mmf_reduce u_reduce (
        .window      (window),
        .ctl         (s2_ctl),
        .filter_mode (filter_mode),
        .result      (result)
    );

    mmf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_emit),
        .push_data (result),
        .pop       (result_valid && !result_stall),
        .head      (head),
        .not_empty (result_valid),
        .count     (fifo_count)
    );

    // Result word
    assign red_out    = head.red;
    assign green_out  = head.green;
    assign blue_out   = head.blue;
    assign alpha_out  = ALPHA_OPAQUE;
    assign frame_last = head.last;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the RGB 3x3 min/max filter: raster frames in, filtered words checked.
module testbench import mmf_pkg::*; ();

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 16;    // output latency plus margin
    localparam int QUIET_LIMIT   = 4000;  // cycles with no word moving on any port
    localparam int MAX_REPORTS   = 100;
    localparam int RANDOM_WORDS  = 2000;
    localparam int PHASE_WORDS   = 120;

    // Index past the last register; the block ignores it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic              cmd;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_word_t;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last;
    } filtered_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 pixel_valid  = 1'b0;
    logic                 pixel_stall;
    logic                 command      = CMD_PIXEL;
    logic [CHAN_W-1:0]    red_in       = '0;
    logic [CHAN_W-1:0]    green_in     = '0;
    logic [CHAN_W-1:0]    blue_in      = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [CHAN_W-1:0]    red_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    blue_out;
    logic [CHAN_W-1:0]    alpha_out;
    logic                 frame_last;

    rgb_word_t pixel_q[$];      // words waiting to be sent
    filtered_t filtered_q[$];   // filtered words still to come out

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned quiet_cycles  = 0;
    int          err_count     = 0;

    // Shadow of the filter state
    logic [PIX_W-1:0] line_above     [MAX_WIDTH];
    logic [PIX_W-1:0] line_two_above [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      in_col, in_row, out_col, out_row;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic             mode_reg;

    rgb_3x3_min_max_filter_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .command      (command),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .alpha_out    (alpha_out),
        .frame_last   (frame_last)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Filter prediction
    // ---------------------------------------------------------------
    function automatic int unsigned active_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == '0)
            return 1;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void restart_stream();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
    endfunction

    function automatic void reset_filter_model();
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        mode_reg   = MODE_MIN;
        restart_stream();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:
            begin
                width_reg = data[FW_W-1:0];
                restart_stream();
            end
            REG_FRAME_HEIGHT:
            begin
                height_reg = data[FH_W-1:0];
                restart_stream();
            end
            REG_FILTER_MODE:
                mode_reg = data[0];
            default:
                ;
        endcase
    endfunction

    // Min or max over the window around (out_row, out_col); 'mid' is the
    // window column (0-based) that holds the center. Returns frame_last.
    function automatic bit emit_filtered(input int unsigned mid, input int unsigned w,
                                         input int unsigned h);
        logic [CHAN_W-1:0] acc [3];
        logic [CHAN_W-1:0] v;
        filtered_t         word;
        int unsigned       c;
        for (int ch = 0; ch < 3; ch++)
            acc[ch] = (mode_reg == MODE_MAX) ? CHAN_EMPTY : CHAN_FULL;
        for (int dr = 0; dr < 3; dr++)
        begin
            if (dr == 0 && out_row < 1)
                continue;
            if (dr == 2 && out_row + 1 >= h)
                continue;
            for (int dc = 0; dc < 3; dc++)
            begin
                c = mid + dc;
                if (dc == 0 && out_col < 1)
                    continue;
                if (dc == 2 && out_col + 1 >= w)
                    continue;
                if (c < 1 || c > 3)
                    continue;
                for (int ch = 0; ch < 3; ch++)
                begin
                    v = win[dr][c-1][CHAN_W*ch +: CHAN_W];
                    if ((mode_reg == MODE_MAX) ? (v > acc[ch]) : (v < acc[ch]))
                        acc[ch] = v;
                end
            end
        end
        word.red   = acc[0];
        word.green = acc[1];
        word.blue  = acc[2];
        word.alpha = ALPHA_OPAQUE;
        word.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
        filtered_q.insert(filtered_q.size(), word);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
        return word.last;
    endfunction

    // One accepted input word: advance the window, queue any filtered word
    function automatic void filter_pixel_word(input rgb_word_t wd);
        int unsigned      w, h, col;
        bit               flushing;
        logic [PIX_W-1:0] pix;
        w        = active_width();
        h        = active_height();
        flushing = (in_row >= h);
        // drain inside a frame is dropped
        if (wd.cmd == CMD_DRAIN && !flushing)
            return;
        pix = flushing ? '0 : {wd.blue, wd.green, wd.red};
        col = in_col;
        // last column of the row two above completes here
        if (col == 0 && in_row >= 2)
        begin
            if (emit_filtered(2, w, h))
            begin
                restart_stream();
                return;
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2]           = line_two_above[col];
        win[1][2]           = line_above[col];
        win[2][2]           = pix;
        line_two_above[col] = line_above[col];
        line_above[col]     = pix;
        if (col >= 1 && in_row >= 1)
        begin
            if (emit_filtered(1, w, h))
            begin
                restart_stream();
                return;
            end
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Pixel driver: predicts each accepted word, then offers the next
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        rgb_word_t next_word;
        if (!rst_n)
            pixel_valid <= 1'b0;
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                next_word.cmd   = command;
                next_word.red   = red_in;
                next_word.green = green_in;
                next_word.blue  = blue_in;
                filter_pixel_word(next_word);
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_word = pixel_q.pop_front();
                    pixel_valid <= 1'b1;
                    command     <= next_word.cmd;
                    red_in      <= next_word.red;
                    green_in    <= next_word.green;
                    blue_in     <= next_word.blue;
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and scoreboard
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : check_results
        filtered_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display({"%0t ns: unexpected word, expected none, ",
                                  "actual %0d/%0d/%0d/%0d/%0d"},
                                 $time, red_out, green_out, blue_out, alpha_out, frame_last);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    check_field("red_out", red_out, want.red);
                    check_field("green_out", green_out, want.green);
                    check_field("blue_out", blue_out, want.blue);
                    check_field("alpha_out", alpha_out, want.alpha);
                    check_field("frame_last", frame_last, want.last);
                end
            end
            result_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Watchdog on cycles where no word moves anywhere
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || cfg_write || (pixel_valid && !pixel_stall)
            || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(7, 0))
            0:       return CHAN_EMPTY;
            1:       return CHAN_FULL;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic void queue_rgb(input logic cmd, input logic [CHAN_W-1:0] r,
                                      input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
        rgb_word_t word;
        word.cmd   = cmd;
        word.red   = r;
        word.green = g;
        word.blue  = b;
        pixel_q.insert(pixel_q.size(), word);
    endfunction

    function automatic void queue_word(input logic cmd);
        queue_rgb(cmd, rand_chan(), rand_chan(), rand_chan());
    endfunction

    // One frame at the current size, with stray drains; may be cut short
    task automatic queue_frame(input bit whole, output int unsigned n);
        int unsigned w, h, cut;
        w   = active_width();
        h   = active_height();
        cut = w * h;
        if (!whole && $urandom_range(9, 0) == 0)
            cut = $urandom_range(cut - 1, 0);
        for (int unsigned i = 0; i < cut; i++)
        begin
            if (!whole && $urandom_range(24, 0) == 0)
                queue_word(CMD_DRAIN);
            queue_word(CMD_PIXEL);
        end
        n = cut;
        // flush: pixels here count as drains
        if (cut == w * h)
        begin
            for (int unsigned i = 0; i <= w; i++)
                queue_word($urandom_range(1, 0) ? CMD_DRAIN : CMD_PIXEL);
            n += w + 1;
            if ($urandom_range(3, 0) == 0)
                queue_word(CMD_DRAIN);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_size(input logic [FW_W-1:0] w, input logic [FH_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, {1'($urandom), w});
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    function automatic void set_idling(input int unsigned mode);
        case (mode % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 88; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
        endcase
    endfunction

    // Hold the sender until every word is sent and every filtered word is back
    task automatic settle_stream();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || pixel_valid || filtered_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int unsigned pick_dim(input int unsigned top);
        if ($urandom_range(15, 0) == 0)
            return 0;
        if ($urandom_range(4, 0) == 0)
            return $urandom_range(top, 9);
        return $urandom_range(8, 1);
    endfunction

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned n, total, phase, phase_words;
        reset_filter_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 3x3 minimum with corner values, a stray drain, a pixel while flushing
        set_idling(0);
        set_size(12'd3, 13'd3);
        write_reg(REG_FILTER_MODE, CFG_W'(MODE_MIN));
        queue_rgb(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        queue_rgb(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        queue_rgb(CMD_PIXEL, 8'd0, 8'd255, 8'd128);
        queue_rgb(CMD_DRAIN, 8'd7, 8'd7, 8'd7);
        queue_rgb(CMD_PIXEL, 8'd85, 8'd170, 8'd1);
        queue_rgb(CMD_PIXEL, 8'd255, 8'd0, 8'd255);
        queue_rgb(CMD_PIXEL, 8'd1, 8'd2, 8'd3);
        queue_rgb(CMD_PIXEL, 8'd254, 8'd253, 8'd252);
        queue_rgb(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        queue_rgb(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        queue_rgb(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
        queue_rgb(CMD_PIXEL, 8'd9, 8'd9, 8'd9);
        queue_rgb(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
        queue_rgb(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
        queue_rgb(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
        settle_stream();

        // single-pixel frame in maximum mode
        set_size(12'd1, 13'd1);
        write_reg(REG_FILTER_MODE, CFG_W'(MODE_MAX));
        queue_rgb(CMD_PIXEL, 8'd17, 8'd34, 8'd51);
        queue_rgb(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
        queue_rgb(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        settle_stream();

        // Random frames; every fourth phase keeps the size so the mode
        // changes in the middle of a frame
        total = 0;
        phase = 0;
        while (total < RANDOM_WORDS)
        begin
            set_idling(phase);
            if (phase % 4 != 3)
                set_size(FW_W'(pick_dim(40)), FH_W'(pick_dim(12)));
            write_reg(REG_FILTER_MODE, CFG_W'($urandom));
            if (phase % 6 == 5)
                write_reg(REG_UNUSED, CFG_W'($urandom));
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                if ($urandom_range(9, 0) == 0)
                begin
                    for (int i = 0; i < 30; i++)
                        queue_word($urandom_range(1, 0) ? CMD_DRAIN : CMD_PIXEL);
                    n = 30;
                end
                else
                    queue_frame(1'b0, n);
                phase_words += n;
            end
            total += phase_words;
            settle_stream();
            phase++;
        end

        // Zero sizes read as a one-pixel frame
        set_idling(0);
        set_size(12'd0, 13'd0);
        queue_frame(1'b1, n);
        queue_frame(1'b1, n);
        settle_stream();

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
